### src/tbb_pkg.sv
`default_nettype none
package tbb_pkg;

	localparam int AxisW      = 2;
	localparam int CoordW     = 32;
	localparam int CoefW      = 16;
	localparam int ScaleW     = 16;
	localparam int ScaleShift = 8;
	localparam int CoefShift  = 14;
	localparam int NumAxes    = 3;
	localparam int NumBounds  = 2 * NumAxes;

	localparam int ProdW = CoordW + ScaleW + 1;
	localparam int SatW  = ProdW - ScaleShift;
	localparam int MulW  = CoefW + CoordW;
	localparam int TermW = MulW - CoefShift;
	localparam int SumW  = TermW + 2;

	typedef struct packed {
		logic [AxisW-1:0]                  axis;
		logic [NumAxes-1:0][CoefW-1:0]     coef;
		logic [CoordW-1:0]                 offset;
		logic [ScaleW-1:0]                 scale;
		logic [NumBounds-1:0][CoordW-1:0]  bnd;
	} item_t;

	typedef struct packed {
		logic [AxisW-1:0]                  axis;
		logic [NumAxes-1:0][CoefW-1:0]     coef;
		logic [CoordW-1:0]                 offset;
		logic [NumBounds-1:0][CoordW-1:0]  scl;
		logic                              clip;
	} scaled_t;

	typedef struct packed {
		logic [AxisW-1:0]                  axis;
		logic [CoordW-1:0]                 offset;
		logic [NumAxes-1:0][TermW-1:0]     lo;
		logic [NumAxes-1:0][TermW-1:0]     hi;
		logic                              clip;
	} ext_t;

	typedef struct packed {
		logic              clip;
		logic [CoordW-1:0] val;
	} sat_t;

	function automatic sat_t sat32(input logic [SatW-1:0] v);
		sat_t r;
		logic hi_any;
		logic hi_all;
		hi_any = |v[SatW-2:CoordW-1];
		hi_all = &v[SatW-2:CoordW-1];
		r.clip = 1'b0;
		r.val  = v[CoordW-1:0];
		if (!v[SatW-1] && hi_any) begin
			r.clip = 1'b1;
			r.val  = {1'b0, {(CoordW-1){1'b1}}};
		end else if (v[SatW-1] && !hi_all) begin
			r.clip = 1'b1;
			r.val  = {1'b1, {(CoordW-1){1'b0}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### src/tbb_scale.sv
`default_nettype none
module tbb_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tbb_pkg::item_t    in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output tbb_pkg::scaled_t  out_data
);

	localparam int ProdW     = tbb_pkg::ProdW;
	localparam int NumBounds = tbb_pkg::NumBounds;

	logic                               v_s1, v_s2;
	logic                               en_s1, en_s2;
	logic [NumBounds-1:0][ProdW-1:0]    prod;
	logic [NumBounds-1:0][ProdW-1:0]    prod_s1;
	tbb_pkg::item_t                     item_s1;
	tbb_pkg::scaled_t                   scl_s2;
	tbb_pkg::scaled_t                   scl_nxt;
	tbb_pkg::sat_t [NumBounds-1:0]      sat;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		for (int i = 0; i < NumBounds; i++) begin
			prod[i] = $signed(in_data.bnd[i]) * $signed({1'b0, in_data.scale});
		end
	end

	always_comb begin
		scl_nxt.axis   = item_s1.axis;
		scl_nxt.coef   = item_s1.coef;
		scl_nxt.offset = item_s1.offset;
		scl_nxt.clip   = 1'b0;
		for (int i = 0; i < NumBounds; i++) begin
			sat[i]         = tbb_pkg::sat32(prod_s1[i][ProdW-1:tbb_pkg::ScaleShift]);
			scl_nxt.scl[i] = sat[i].val;
			scl_nxt.clip   = scl_nxt.clip | sat[i].clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			prod_s1 <= prod;
			item_s1 <= in_data;
		end
		if (en_s2 && v_s1) scl_s2 <= scl_nxt;
	end

	assign out_valid = v_s2;
	assign out_data  = scl_s2;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2))
		else $error("scale stages stall with a free slot");

endmodule
`default_nettype wire

### src/tbb_rot.sv
`default_nettype none
module tbb_rot (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tbb_pkg::scaled_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output tbb_pkg::ext_t     out_data
);

	localparam int MulW      = tbb_pkg::MulW;
	localparam int TermW     = tbb_pkg::TermW;
	localparam int NumAxes   = tbb_pkg::NumAxes;
	localparam int NumBounds = tbb_pkg::NumBounds;

	logic                               v_s3, v_s4;
	logic                               en_s3, en_s4;
	logic [NumBounds-1:0][MulW-1:0]     mul;
	logic [NumBounds-1:0][TermW-1:0]    term_s3;
	logic [tbb_pkg::AxisW-1:0]          axis_s3;
	logic [tbb_pkg::CoordW-1:0]         offset_s3;
	logic                               clip_s3;
	tbb_pkg::ext_t                      ext_nxt;
	tbb_pkg::ext_t                      ext_s4;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	for (genvar i = 0; i < NumBounds; i++) begin : g_mul
		assign mul[i] = $signed(in_data.coef[i/2]) * $signed(in_data.scl[i]);
	end

	always_comb begin
		ext_nxt.axis   = axis_s3;
		ext_nxt.offset = offset_s3;
		ext_nxt.clip   = clip_s3;
		for (int a = 0; a < NumAxes; a++) begin
			if ($signed(term_s3[2*a]) < $signed(term_s3[2*a+1])) begin
				ext_nxt.lo[a] = term_s3[2*a];
				ext_nxt.hi[a] = term_s3[2*a+1];
			end else begin
				ext_nxt.lo[a] = term_s3[2*a+1];
				ext_nxt.hi[a] = term_s3[2*a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			for (int i = 0; i < NumBounds; i++) begin
				term_s3[i] <= mul[i][MulW-1:tbb_pkg::CoefShift];
			end
			axis_s3   <= in_data.axis;
			offset_s3 <= in_data.offset;
			clip_s3   <= in_data.clip;
		end
		if (en_s4 && v_s3) ext_s4 <= ext_nxt;
	end

	assign out_valid = v_s4;
	assign out_data  = ext_s4;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s3 && v_s4))
		else $error("rotate stages stall with a free slot");

	a_lo_hi: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> ($signed(ext_s4.lo[0]) <= $signed(ext_s4.hi[0]))
			&& ($signed(ext_s4.lo[1]) <= $signed(ext_s4.hi[1]))
			&& ($signed(ext_s4.lo[2]) <= $signed(ext_s4.hi[2])))
		else $error("per-axis term extremes out of order");

endmodule
`default_nettype wire

### src/tbb_sum.sv
`default_nettype none
module tbb_sum (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  tbb_pkg::ext_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tbb_pkg::AxisW-1:0]          axis_out,
	output logic signed [tbb_pkg::CoordW-1:0]  world_min,
	output logic signed [tbb_pkg::CoordW-1:0]  world_max,
	output logic                               clipped
);

	localparam int CoordW = tbb_pkg::CoordW;
	localparam int TermW  = tbb_pkg::TermW;
	localparam int SumW   = tbb_pkg::SumW;
	localparam int SatW   = tbb_pkg::SatW;

	logic                       v_s5, v_s6;
	logic                       en_s5, en_s6;
	logic [SumW-1:0]            lo_sum, hi_sum;
	logic [SumW-1:0]            lo_s5, hi_s5;
	logic [tbb_pkg::AxisW-1:0]  axis_s5, axis_s6;
	logic                       clip_s5, clip_s6;
	logic [CoordW-1:0]          min_s6, max_s6;
	tbb_pkg::sat_t              sat_lo, sat_hi;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign in_ready = en_s5;

	assign lo_sum = {{(SumW-CoordW){in_data.offset[CoordW-1]}}, in_data.offset}
		+ {{(SumW-TermW){in_data.lo[0][TermW-1]}}, in_data.lo[0]}
		+ {{(SumW-TermW){in_data.lo[1][TermW-1]}}, in_data.lo[1]}
		+ {{(SumW-TermW){in_data.lo[2][TermW-1]}}, in_data.lo[2]};
	assign hi_sum = {{(SumW-CoordW){in_data.offset[CoordW-1]}}, in_data.offset}
		+ {{(SumW-TermW){in_data.hi[0][TermW-1]}}, in_data.hi[0]}
		+ {{(SumW-TermW){in_data.hi[1][TermW-1]}}, in_data.hi[1]}
		+ {{(SumW-TermW){in_data.hi[2][TermW-1]}}, in_data.hi[2]};

	assign sat_lo = tbb_pkg::sat32({{(SatW-SumW){lo_s5[SumW-1]}}, lo_s5});
	assign sat_hi = tbb_pkg::sat32({{(SatW-SumW){hi_s5[SumW-1]}}, hi_s5});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			lo_s5   <= lo_sum;
			hi_s5   <= hi_sum;
			axis_s5 <= in_data.axis;
			clip_s5 <= in_data.clip;
		end
		if (en_s6 && v_s5) begin
			min_s6  <= sat_lo.val;
			max_s6  <= sat_hi.val;
			axis_s6 <= axis_s5;
			clip_s6 <= clip_s5 | sat_lo.clip | sat_hi.clip;
		end
	end

	assign out_valid = v_s6;
	assign axis_out  = axis_s6;
	assign world_min = min_s6;
	assign world_max = max_s6;
	assign clipped   = clip_s6;

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (world_min <= world_max))
		else $error("world bounds out of order");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s5 && v_s6))
		else $error("sum stages stall with a free slot");

endmodule
`default_nettype wire

### src/transformed_box_bounds.sv
`default_nettype none
// World bounds of a scaled, rotated and translated box, one output axis per beat.
// An accepted input beat passes through each registered stage below in turn; a new
// beat is taken every cycle while results drain. Stages: scale multiply, scale
// saturate, rotation multiply, per-axis min/max, offset add, final saturate.
// Each stall stage is an elastic register, so bubbles collapse and a held
// result never blocks items behind it while free slots remain.
module transformed_box_bounds (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic [tbb_pkg::AxisW-1:0]          axis,
	input  logic signed [tbb_pkg::CoefW-1:0]   coef_x,
	input  logic signed [tbb_pkg::CoefW-1:0]   coef_y,
	input  logic signed [tbb_pkg::CoefW-1:0]   coef_z,
	input  logic signed [tbb_pkg::CoordW-1:0]  offset,
	input  logic [tbb_pkg::ScaleW-1:0]         scale,
	input  logic signed [tbb_pkg::CoordW-1:0]  box_min_x,
	input  logic signed [tbb_pkg::CoordW-1:0]  box_max_x,
	input  logic signed [tbb_pkg::CoordW-1:0]  box_min_y,
	input  logic signed [tbb_pkg::CoordW-1:0]  box_max_y,
	input  logic signed [tbb_pkg::CoordW-1:0]  box_min_z,
	input  logic signed [tbb_pkg::CoordW-1:0]  box_max_z,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [tbb_pkg::AxisW-1:0]          axis_out,
	output logic signed [tbb_pkg::CoordW-1:0]  world_min,
	output logic signed [tbb_pkg::CoordW-1:0]  world_max,
	output logic                               clipped
);

	tbb_pkg::item_t    item;
	tbb_pkg::scaled_t  scl;
	tbb_pkg::ext_t     ext;
	logic              scl_valid, scl_ready;
	logic              ext_valid, ext_ready;

	always_comb begin
		item.axis    = axis;
		item.coef[0] = coef_x;
		item.coef[1] = coef_y;
		item.coef[2] = coef_z;
		item.offset  = offset;
		item.scale   = scale;
		item.bnd[0]  = box_min_x;
		item.bnd[1]  = box_max_x;
		item.bnd[2]  = box_min_y;
		item.bnd[3]  = box_max_y;
		item.bnd[4]  = box_min_z;
		item.bnd[5]  = box_max_z;
	end

	tbb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (item_ready),
		.in_data   (item),
		.out_valid (scl_valid),
		.out_ready (scl_ready),
		.out_data  (scl)
	);

	tbb_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scl_valid),
		.in_ready  (scl_ready),
		.in_data   (scl),
		.out_valid (ext_valid),
		.out_ready (ext_ready),
		.out_data  (ext)
	);

	tbb_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ext_valid),
		.in_ready  (ext_ready),
		.in_data   (ext),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.axis_out  (axis_out),
		.world_min (world_min),
		.world_max (world_max),
		.clipped   (clipped)
	);

endmodule
`default_nettype wire
